>>> hw/rtl/gsaa_pkg.sv
package gsaa_pkg;

   typedef struct packed {
      logic signed [15:0] log_scale_a;
      logic signed [15:0] log_scale_b;
      logic signed [15:0] log_scale_c;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] opacity_logit;
      logic signed [15:0] dc_red;
      logic signed [15:0] dc_green;
      logic signed [15:0] dc_blue;
   } req_type;

   typedef struct packed {
      logic [23:0]        size_first;
      logic [23:0]        size_second;
      logic [23:0]        size_third;
      logic signed [15:0] rot_out_x;
      logic signed [15:0] rot_out_y;
      logic signed [15:0] rot_out_z;
      logic signed [15:0] rot_out_w;
      logic signed [15:0] color_red;
      logic signed [15:0] color_green;
      logic signed [15:0] color_blue;
      logic [16:0]        alpha;
   } rsp_type;

   localparam int EXP_N_W = 9;
   localparam int EXP_P_W = 31;
   localparam int EXP_LAT = 7;

   localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
   localparam logic [28:0] C0_Q30    = 29'd302896976;
   localparam logic [30:0] ONE_Q30   = 31'd1073741824;
   localparam logic [30:0] EXP_C1    = 31'd744261118;
   localparam logic [30:0] EXP_C2    = 31'd257941248;
   localparam logic [30:0] EXP_C3    = 31'd59597083;
   localparam logic [30:0] EXP_C4    = 31'd10327387;
   localparam logic [30:0] EXP_C5    = 31'd1431680;
   localparam logic [30:0] EXP_C6    = 31'd165394;

   localparam logic [23:0] SIZE_SAT   = 24'hFFFFFF;
   localparam logic [15:0] ROT_ONE    = 16'd16384;
   localparam logic [16:0] ALPHA_ONE  = 17'd65536;
   localparam int          COLOR_HALF = 2048;

   localparam int SQRT_W   = 31;
   localparam int QDIV_W   = 16;
   localparam int QNUM_W   = 44;
   localparam int ADIV_W   = 17;
   localparam int ANUM_W   = 47;
   localparam int ADEN_W   = 32;

   localparam int COL_STG   = 2;
   localparam int SZ_STG    = EXP_LAT + 2;
   localparam int AL_Q_STG  = EXP_LAT + 2 + ADIV_W;
   localparam int AL_STG    = AL_Q_STG + 1;
   localparam int Q_ROOT_STG = 2 + SQRT_W;
   localparam int Q_NUM_STG = Q_ROOT_STG + 1;
   localparam int Q_QUO_STG = Q_NUM_STG + QDIV_W;
   localparam int LAT       = Q_QUO_STG + 1;

   function automatic logic [30:0] exp_coef(input logic [2:0] k);
      logic [30:0] c;
      case (k)
         3'd0: c = EXP_C5;
         3'd1: c = EXP_C4;
         3'd2: c = EXP_C3;
         3'd3: c = EXP_C2;
         3'd4: c = EXP_C1;
         default: c = ONE_Q30;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/gsaa_delay.sv
module gsaa_delay
   import gsaa_pkg::*;
#(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] dly_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign q = dly_ff[DEPTH-1];

endmodule

>>> hw/rtl/gsaa_exp.sv
module gsaa_exp
   import gsaa_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [15:0]        raw,
   output logic [EXP_P_W-1:0]        p,
   output logic signed [EXP_N_W-1:0] n
);

   logic signed [45:0]        t;
   logic signed [45:0]        lg;
   logic signed [45:0]        ip;
   logic [29:0]               f_ff   [6];
   logic signed [EXP_N_W-1:0] n_ff   [7];
   logic [EXP_P_W-1:0]        acc_ff [6];
   logic [EXP_P_W-1:0]        acc_in [6];

   assign t  = 46'(raw) * 46'($signed({1'b0, LOG2E_Q28}));
   assign lg = t >>> (FRAC_BITS + 4);
   assign ip = lg >>> 24;

   always_comb begin
      logic [EXP_P_W-1:0] mul_a;
      logic [60:0]        prod;
      for (int k = 0; k < 6; k++) begin
         if (k == 0) begin
            mul_a = EXP_C6;
         end else begin
            mul_a = acc_ff[k-1];
         end
         prod      = 61'(mul_a) * 61'(f_ff[k]);
         acc_in[k] = exp_coef(3'(k)) + prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff[0] <= {lg[23:0], 6'd0};
         n_ff[0] <= ip[EXP_N_W-1:0];
         for (int k = 1; k < 6; k++) begin
            f_ff[k] <= f_ff[k-1];
         end
         for (int k = 1; k < 7; k++) begin
            n_ff[k] <= n_ff[k-1];
         end
         for (int k = 0; k < 6; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   assign p = acc_ff[5];
   assign n = n_ff[6];

endmodule

>>> hw/rtl/gsaa_div.sv
module gsaa_div
   import gsaa_pkg::*;
#(
   parameter int NUM_W = 47,
   parameter int DEN_W = 32,
   parameter int Q_W   = 17
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   logic [DEN_W-1:0] rem_ff [Q_W-1];
   logic [Q_W-1:0]   low_ff [Q_W-1];
   logic [DEN_W-1:0] den_ff [Q_W-1];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [DEN_W-1:0] rem_in [Q_W];
   logic [Q_W-1:0]   low_in [Q_W];
   logic [DEN_W-1:0] den_in [Q_W];
   logic [Q_W-1:0]   q_in   [Q_W];

   always_comb begin
      logic [DEN_W-1:0] rem_p;
      logic [Q_W-1:0]   low_p;
      logic [DEN_W-1:0] den_p;
      logic [Q_W-1:0]   q_p;
      logic [DEN_W:0]   rem_sh;
      logic             ge;
      for (int i = 0; i < Q_W; i++) begin
         if (i == 0) begin
            rem_p = DEN_W'(num >> Q_W);
            low_p = num[Q_W-1:0];
            den_p = den;
            q_p   = '0;
         end else begin
            rem_p = rem_ff[i-1];
            low_p = low_ff[i-1];
            den_p = den_ff[i-1];
            q_p   = q_ff[i-1];
         end
         rem_sh    = {rem_p, low_p[Q_W-1]};
         ge        = rem_sh >= (DEN_W+1)'(den_p);
         rem_in[i] = ge ? DEN_W'(rem_sh - (DEN_W+1)'(den_p)) : DEN_W'(rem_sh);
         low_in[i] = low_p << 1;
         den_in[i] = den_p;
         q_in[i]   = {q_p[Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < Q_W - 1; i++) begin
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
            den_ff[i] <= den_in[i];
         end
         for (int i = 0; i < Q_W; i++) begin
            q_ff[i] <= q_in[i];
         end
      end
   end

   assign quo = q_ff[Q_W-1];

endmodule

>>> hw/rtl/gsaa_sqrt.sv
module gsaa_sqrt
   import gsaa_pkg::*;
#(
   parameter int R_W = 31
) (
   input  logic               clock,
   input  logic               en,
   input  logic [2*R_W-1:0]   v,
   output logic [R_W-1:0]     root
);

   logic [R_W+1:0]   rem_ff  [R_W-1];
   logic [2*R_W-1:0] v_ff    [R_W-1];
   logic [R_W-1:0]   root_ff [R_W];
   logic [R_W+1:0]   rem_in  [R_W];
   logic [2*R_W-1:0] v_in    [R_W];
   logic [R_W-1:0]   root_in [R_W];

   always_comb begin
      logic [R_W+1:0]   rem_p;
      logic [2*R_W-1:0] v_p;
      logic [R_W-1:0]   root_p;
      logic [R_W+3:0]   rem_sh;
      logic [R_W+3:0]   trial;
      logic             ge;
      for (int i = 0; i < R_W; i++) begin
         if (i == 0) begin
            rem_p  = '0;
            v_p    = v;
            root_p = '0;
         end else begin
            rem_p  = rem_ff[i-1];
            v_p    = v_ff[i-1];
            root_p = root_ff[i-1];
         end
         rem_sh     = {rem_p, v_p[2*R_W-1 -: 2]};
         trial      = (R_W+4)'({root_p, 2'b01});
         ge         = rem_sh >= trial;
         rem_in[i]  = ge ? (R_W+2)'(rem_sh - trial) : (R_W+2)'(rem_sh);
         v_in[i]    = v_p << 2;
         root_in[i] = {root_p[R_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < R_W - 1; i++) begin
            rem_ff[i] <= rem_in[i];
            v_ff[i]   <= v_in[i];
         end
         for (int i = 0; i < R_W; i++) begin
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign root = root_ff[R_W-1];

endmodule

>>> hw/rtl/gaussian_splat_attribute_activation_top.sv
// Gaussian splat attribute activation.
// One raw splat enters on the req_ channel (req_valid/req_ready, payload req_data)
// and one render-ready splat leaves on the rsp_ channel (rsp_valid/rsp_ready,
// payload rsp_data). A transfer takes place when valid and ready are both high.
// Sizes are POS_SCALE*exp(log scale) in Q16.8 with the second and third swapped,
// the quaternion is normalized to Q1.14 and reordered to (x,-z,-y,w), alpha is
// the sigmoid of the opacity logit (65536 = 1.0), colors are 0.5 + C0*dc in Q4.12.
// The quaternion path sets the latency from the input transfer to rsp_valid:
// a 31-stage square root followed by a 16-stage divider.
// One splat per cycle unless the receiver stalls; every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears only the valid bits; no clearing pass is needed and the block
// accepts a transfer in the first cycle after reset.
module gaussian_splat_attribute_activation_top
   import gsaa_pkg::*;
#(
   parameter int IN_FRAC_BITS = 12,
   parameter int POS_SCALE    = 100
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int POS_W = $clog2(POS_SCALE + 1);
   localparam int SV_W  = POS_W + EXP_P_W;
   localparam logic [32:0] NZ_MIN =
      33'(((64'd1 << (2 * IN_FRAC_BITS)) + 64'd99999999) / 64'd100000000);
   localparam logic signed [46:0] COL_RND = 47'sd1 <<< (IN_FRAC_BITS + 17);

   function automatic logic [23:0] size_round(input logic [SV_W-1:0] v,
                                              input logic signed [EXP_N_W-1:0] n);
      int          nv;
      logic [5:0]  sh;
      logic [63:0] sum;
      logic [63:0] r;
      logic [23:0] res;
      nv = int'(n);
      sh = 6'(22 - nv);
      if (nv >= 16) begin
         res = SIZE_SAT;
      end else if (nv < -40) begin
         res = '0;
      end else begin
         sum = 64'(v) + (64'd1 << (sh - 6'd1));
         r   = sum >> sh;
         res = (r > 64'(SIZE_SAT)) ? SIZE_SAT : r[23:0];
      end
      return res;
   endfunction

   function automatic logic [EXP_P_W-1:0] alpha_d(input logic [EXP_P_W-1:0] p,
                                                  input logic signed [EXP_N_W-1:0] n);
      int                 k;
      logic [63:0]        sum;
      logic [EXP_P_W-1:0] res;
      k = -int'(n);
      if (k <= 0) begin
         res = p;
      end else if (k > 40) begin
         res = '0;
      end else begin
         sum = 64'(p) + (64'd1 << (k - 1));
         res = EXP_P_W'(sum >> k);
      end
      return res;
   endfunction

   function automatic logic [15:0] color_sat(input logic signed [45:0] prod);
      logic signed [46:0] c;
      logic [15:0]        res;
      c = (47'(prod) + COL_RND) >>> (IN_FRAC_BITS + 18);
      c = c + 47'(COLOR_HALF);
      if (c > 47'sd32767) begin
         res = 16'h7FFF;
      end else if (c < -47'sd32768) begin
         res = 16'h8000;
      end else begin
         res = c[15:0];
      end
      return res;
   endfunction

   function automatic logic [15:0] rot_part(input logic [QDIV_W-1:0] q, input logic neg);
      logic [15:0] mag;
      mag = (16'(q) > ROT_ONE) ? ROT_ONE : 16'(q);
      return neg ? 16'(-mag) : mag;
   endfunction

   logic           en;
   logic [LAT:0]   vld_ff;
   logic [LAT:0]   vld_in;
   req_type        in_ff;

   assign en        = !vld_ff[LAT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT];
   assign vld_in    = {vld_ff[LAT-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;
      end
   end

   // sizes
   logic signed [15:0]        sz_raw  [3];
   logic [EXP_P_W-1:0]        sz_p    [3];
   logic signed [EXP_N_W-1:0] sz_n    [3];
   logic [SV_W-1:0]           sz_v_ff [3];
   logic signed [EXP_N_W-1:0] sz_n_ff [3];
   logic [2:0][23:0]          sz_ff;
   logic [2:0][23:0]          sz_d;

   assign sz_raw[0] = in_ff.log_scale_a;
   assign sz_raw[1] = in_ff.log_scale_c;
   assign sz_raw[2] = in_ff.log_scale_b;

   for (genvar g = 0; g < 3; g++) begin : g_size
      gsaa_exp #(.FRAC_BITS(IN_FRAC_BITS)) u_exp (
         .clock (clock),
         .en    (en),
         .raw   (sz_raw[g]),
         .p     (sz_p[g]),
         .n     (sz_n[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sz_v_ff[i] <= SV_W'(POS_SCALE) * SV_W'(sz_p[i]);
            sz_n_ff[i] <= sz_n[i];
            sz_ff[i]   <= size_round(sz_v_ff[i], sz_n_ff[i]);
         end
      end
   end

   gsaa_delay #(.W(72), .DEPTH(LAT - SZ_STG)) u_size_dly (
      .clock (clock),
      .en    (en),
      .d     (sz_ff),
      .q     (sz_d)
   );

   // alpha
   logic signed [15:0]        al_raw;
   logic [EXP_P_W-1:0]        al_p;
   logic signed [EXP_N_W-1:0] al_n;
   logic [EXP_P_W-1:0]        al_d_ff;
   logic [ADEN_W-1:0]         al_den_in;
   logic [ANUM_W-1:0]         al_num_ff;
   logic [ADEN_W-1:0]         al_den_ff;
   logic [ADIV_W-1:0]         al_q;
   logic                      al_neg;
   logic [16:0]               alpha_ff;
   logic [16:0]               alpha_out;

   assign al_raw = in_ff.opacity_logit[15] ? in_ff.opacity_logit : -in_ff.opacity_logit;
   assign al_den_in = ADEN_W'(ONE_Q30) + ADEN_W'(al_d_ff);

   gsaa_exp #(.FRAC_BITS(IN_FRAC_BITS)) u_alpha_exp (
      .clock (clock),
      .en    (en),
      .raw   (al_raw),
      .p     (al_p),
      .n     (al_n)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         al_d_ff   <= alpha_d(al_p, al_n);
         al_den_ff <= al_den_in;
         al_num_ff <= (ANUM_W'(al_d_ff) << 16) + ANUM_W'(al_den_in >> 1);
         alpha_ff  <= al_neg ? al_q : ALPHA_ONE - al_q;
      end
   end

   gsaa_div #(.NUM_W(ANUM_W), .DEN_W(ADEN_W), .Q_W(ADIV_W)) u_alpha_div (
      .clock (clock),
      .en    (en),
      .num   (al_num_ff),
      .den   (al_den_ff),
      .quo   (al_q)
   );

   gsaa_delay #(.W(1), .DEPTH(AL_Q_STG)) u_alpha_sign_dly (
      .clock (clock),
      .en    (en),
      .d     (in_ff.opacity_logit[15]),
      .q     (al_neg)
   );

   gsaa_delay #(.W(17), .DEPTH(LAT - AL_STG)) u_alpha_dly (
      .clock (clock),
      .en    (en),
      .d     (alpha_ff),
      .q     (alpha_out)
   );

   // colors
   logic signed [15:0] col_raw     [3];
   logic signed [45:0] col_prod_ff [3];
   logic [2:0][15:0]   col_ff;
   logic [2:0][15:0]   col_d;

   assign col_raw[0] = in_ff.dc_red;
   assign col_raw[1] = in_ff.dc_green;
   assign col_raw[2] = in_ff.dc_blue;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            col_prod_ff[i] <= 46'(col_raw[i]) * 46'($signed({1'b0, C0_Q30}));
            col_ff[i]      <= color_sat(col_prod_ff[i]);
         end
      end
   end

   gsaa_delay #(.W(48), .DEPTH(LAT - COL_STG)) u_color_dly (
      .clock (clock),
      .en    (en),
      .d     (col_ff),
      .q     (col_d)
   );

   // quaternion: index 0 = w, 1 = x, 2 = y, 3 = z
   logic signed [15:0]  qc       [4];
   logic [3:0][15:0]    q_mag;
   logic [3:0][15:0]    q_mag_d;
   logic [3:0]          q_sgn;
   logic [3:0]          q_sgn_d;
   logic [30:0]         q_sq_ff  [4];
   logic [32:0]         q_ss_in;
   logic [32:0]         q_ss_ff;
   logic                q_nz_ff;
   logic                q_nz_d;
   logic [SQRT_W-1:0]   q_s;
   logic [QNUM_W-1:0]   q_num_ff [4];
   logic [SQRT_W-1:0]   q_den_ff;
   logic [QDIV_W-1:0]   q_quo    [4];
   logic [3:0][15:0]    rot_ff;

   assign qc[0] = in_ff.quat_w;
   assign qc[1] = in_ff.quat_x;
   assign qc[2] = in_ff.quat_y;
   assign qc[3] = in_ff.quat_z;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_sgn[i] = qc[i][15];
         q_mag[i] = qc[i][15] ? 16'(-qc[i]) : 16'(qc[i]);
      end
   end

   assign q_ss_in = 33'(q_sq_ff[0]) + 33'(q_sq_ff[1]) + 33'(q_sq_ff[2]) + 33'(q_sq_ff[3]);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            q_sq_ff[i]  <= 31'(32'(qc[i]) * 32'(qc[i]));
            q_num_ff[i] <= (QNUM_W'(q_mag_d[i]) << 28) + QNUM_W'(q_s >> 1);
         end
         q_ss_ff  <= q_ss_in;
         q_nz_ff  <= q_ss_in >= NZ_MIN;
         q_den_ff <= q_s;
         if (q_nz_d) begin
            rot_ff[0] <= rot_part(q_quo[1], q_sgn_d[1]);
            rot_ff[1] <= 16'(-rot_part(q_quo[3], q_sgn_d[3]));
            rot_ff[2] <= 16'(-rot_part(q_quo[2], q_sgn_d[2]));
            rot_ff[3] <= rot_part(q_quo[0], q_sgn_d[0]);
         end else begin
            rot_ff[0] <= '0;
            rot_ff[1] <= '0;
            rot_ff[2] <= '0;
            rot_ff[3] <= ROT_ONE;
         end
      end
   end

   gsaa_sqrt #(.R_W(SQRT_W)) u_sqrt (
      .clock (clock),
      .en    (en),
      .v     ((2 * SQRT_W)'(q_ss_ff) << 28),
      .root  (q_s)
   );

   gsaa_delay #(.W(64), .DEPTH(Q_ROOT_STG)) u_mag_dly (
      .clock (clock),
      .en    (en),
      .d     (q_mag),
      .q     (q_mag_d)
   );

   gsaa_delay #(.W(4), .DEPTH(Q_QUO_STG)) u_sign_dly (
      .clock (clock),
      .en    (en),
      .d     (q_sgn),
      .q     (q_sgn_d)
   );

   gsaa_delay #(.W(1), .DEPTH(Q_QUO_STG - 2)) u_nz_dly (
      .clock (clock),
      .en    (en),
      .d     (q_nz_ff),
      .q     (q_nz_d)
   );

   for (genvar g = 0; g < 4; g++) begin : g_qdiv
      gsaa_div #(.NUM_W(QNUM_W), .DEN_W(SQRT_W), .Q_W(QDIV_W)) u_div (
         .clock (clock),
         .en    (en),
         .num   (q_num_ff[g]),
         .den   (q_den_ff),
         .quo   (q_quo[g])
      );
   end

   always_comb begin
      rsp_data.size_first  = sz_d[0];
      rsp_data.size_second = sz_d[1];
      rsp_data.size_third  = sz_d[2];
      rsp_data.rot_out_x   = rot_ff[0];
      rsp_data.rot_out_y   = rot_ff[1];
      rsp_data.rot_out_z   = rot_ff[2];
      rsp_data.rot_out_w   = rot_ff[3];
      rsp_data.color_red   = col_d[0];
      rsp_data.color_green = col_d[1];
      rsp_data.color_blue  = col_d[2];
      rsp_data.alpha       = alpha_out;
   end

   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("intake open while result stalled");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer lost at intake");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.alpha <= ALPHA_ONE)
      else $error("alpha above one");

   a_rot_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_data.rot_out_w) <= $signed(ROT_ONE) &&
                    $signed(rsp_data.rot_out_w) >= -$signed(ROT_ONE))
      else $error("rotation w out of range");

endmodule

>>> bench/splat_activation_checker.sv
`timescale 1ns / 1ps
module splat_activation_checker
   import gsaa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      splats_checked
);

   localparam longint LOG2E = 387270501;
   localparam longint C0 = 302896976;
   localparam longint ONE = 64'd1073741824;

   rsp_type activated_splats[$];

   function automatic longint floor_div2(input longint v, input int sh);
      return v >>> sh;
   endfunction

   function automatic longint exp_mant(input longint raw, output longint n);
      longint t, lg, ip, f, acc;
      t = raw * LOG2E;
      lg = floor_div2(t, 16);
      ip = floor_div2(lg, 24);
      f = (lg - ip * 16777216) << 6;
      acc = 165394;
      acc = 1431680 + ((acc * f) >> 30);
      acc = 10327387 + ((acc * f) >> 30);
      acc = 59597083 + ((acc * f) >> 30);
      acc = 257941248 + ((acc * f) >> 30);
      acc = 744261118 + ((acc * f) >> 30);
      n = ip;
      return ONE + ((acc * f) >> 30);
   endfunction

   function automatic logic [23:0] size_value(input longint raw);
      longint n, p, sh;
      logic [63:0] v, r;
      p = exp_mant(raw, n);
      if (n >= 16) return SIZE_SAT;
      sh = 22 - n;
      if (sh > 62) return 0;
      v = 100 * p;
      r = (v + (64'd1 << (sh - 1))) >> sh;
      return r > 64'hFFFFFF ? SIZE_SAT : r[23:0];
   endfunction

   function automatic logic [16:0] alpha_value(input longint raw);
      longint n, p, d, den, q;
      p = exp_mant(raw < 0 ? raw : -raw, n);
      if (n >= 0) d = p;
      else if (-n > 40) d = 0;
      else d = (p + (64'sd1 << (-n - 1))) >> (-n);
      den = ONE + d;
      q = ((d << 16) + den / 2) / den;
      return raw < 0 ? q[16:0] : 17'(65536 - q);
   endfunction

   function automatic logic [15:0] color_value(input longint raw);
      longint c;
      c = floor_div2(raw * C0 + (64'sd1 << 29), 30) + COLOR_HALF;
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      return c[15:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] unit_part(input longint c, input logic [63:0] s);
      logic [63:0] m, v;
      m = c < 0 ? -c : c;
      v = ((m << 28) + s / 2) / s;
      if (v > 16384) v = 16384;
      return c < 0 ? 16'(-v) : v[15:0];
   endfunction

   function automatic rsp_type activate(input req_type r);
      rsp_type o;
      longint w, x, y, z;
      logic [63:0] ss, s;
      logic [15:0] nw, nx, ny, nz;
      w = r.quat_w; x = r.quat_x; y = r.quat_y; z = r.quat_z;
      ss = w * w + x * x + y * y + z * z;
      nw = ROT_ONE; nx = 0; ny = 0; nz = 0;
      if (ss * 100000000 >= (64'd1 << 24)) begin
         s = int_sqrt(ss << 28);
         if (s != 0) begin
            nw = unit_part(w, s); nx = unit_part(x, s);
            ny = unit_part(y, s); nz = unit_part(z, s);
         end
      end
      o.size_first = size_value(r.log_scale_a);
      o.size_second = size_value(r.log_scale_c);
      o.size_third = size_value(r.log_scale_b);
      o.rot_out_x = nx;
      o.rot_out_y = -nz;
      o.rot_out_z = -ny;
      o.rot_out_w = nw;
      o.color_red = color_value(r.dc_red);
      o.color_green = color_value(r.dc_green);
      o.color_blue = color_value(r.dc_blue);
      o.alpha = alpha_value(r.opacity_logit);
      return o;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("splat %0d: %s got %0d want %0d", splats_checked, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      splats_checked = 0;
   end

   assign pending_count = activated_splats.size();

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready) activated_splats.push_back(activate(req_data));
         if (rsp_valid && rsp_ready) begin
            if (activated_splats.size() == 0) begin
               report("unexpected transfer", 0, 0);
            end else begin
               e = activated_splats.pop_front();
               if (rsp_data.size_first !== e.size_first)
                  report("size_first", rsp_data.size_first, e.size_first);
               if (rsp_data.size_second !== e.size_second)
                  report("size_second", rsp_data.size_second, e.size_second);
               if (rsp_data.size_third !== e.size_third)
                  report("size_third", rsp_data.size_third, e.size_third);
               if (rsp_data.rot_out_x !== e.rot_out_x)
                  report("rot_out_x", rsp_data.rot_out_x, e.rot_out_x);
               if (rsp_data.rot_out_y !== e.rot_out_y)
                  report("rot_out_y", rsp_data.rot_out_y, e.rot_out_y);
               if (rsp_data.rot_out_z !== e.rot_out_z)
                  report("rot_out_z", rsp_data.rot_out_z, e.rot_out_z);
               if (rsp_data.rot_out_w !== e.rot_out_w)
                  report("rot_out_w", rsp_data.rot_out_w, e.rot_out_w);
               if (rsp_data.color_red !== e.color_red)
                  report("color_red", rsp_data.color_red, e.color_red);
               if (rsp_data.color_green !== e.color_green)
                  report("color_green", rsp_data.color_green, e.color_green);
               if (rsp_data.color_blue !== e.color_blue)
                  report("color_blue", rsp_data.color_blue, e.color_blue);
               if (rsp_data.alpha !== e.alpha)
                  report("alpha", rsp_data.alpha, e.alpha);
            end
            splats_checked++;
         end
      end
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import gsaa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count, pending_count, splats_checked;
   int      idle_cycles = 0;
   bit      hold_sink = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   gaussian_splat_attribute_activation_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   splat_activation_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .splats_checked(splats_checked)
   );

   function automatic logic [15:0] pick_field(input int mode);
      case (mode)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 8192) - 4096);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_splat(input req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_type fill_all(input logic [15:0] v);
      req_type r;
      r = {11{v}};
      return r;
   endfunction

   task automatic run_sender;
      req_type r;
      int mode;
      send_splat(fill_all(16'h0000), 0);
      send_splat(fill_all(16'h7FFF), 0);
      send_splat(fill_all(16'h8000), 0);
      send_splat(fill_all(16'hFFFF), 0);
      send_splat(fill_all(16'h0001), 0);
      r = fill_all(16'h1000);
      r.quat_x = 0; r.quat_y = 0; r.quat_z = 0;
      send_splat(r, 0);
      r.quat_w = 16'sh8000;
      send_splat(r, 1);
      r.quat_w = 0; r.quat_z = 1;
      send_splat(r, 0);
      r.log_scale_a = 16'sd32767; r.log_scale_b = -16'sd32768; r.log_scale_c = 16'sd19000;
      r.opacity_logit = 16'sd30000; r.dc_red = 16'sd32767; r.dc_green = -16'sd32768;
      send_splat(r, 0);
      r.log_scale_a = -16'sd30000; r.opacity_logit = -16'sd30000;
      r.quat_w = 16'sh7FFF; r.quat_x = 16'sh7FFF; r.quat_y = 16'sh8000;
      send_splat(r, 2);
      for (int i = 0; i < 700; i++) begin
         if (i == 350) begin
            req_valid <= 0;
            @(posedge clock);
            wait (pending_count == 0);
            @(posedge clock);
         end
         mode = $urandom_range(0, 9);
         for (int f = 0; f < 11; f++)
            r[f*16 +: 16] = pick_field(mode < 3 ? $urandom_range(0, 4) : 4 - (mode & 1));
         send_splat(r, $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0);
      end
      req_valid <= 0;
      @(posedge clock);
   endtask

   initial begin
      rsp_ready <= 0;
      @(posedge clock);
      while (1) begin
         if (hold_sink) begin
            rsp_ready <= 0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (300) @(posedge clock);
      hold_sink = 1;
      repeat (200) @(posedge clock);
      hold_sink = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog after %0d idle cycles", idle_cycles);
         $display("gaussian_splat_attribute_activation_top: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      run_sender();
      wait (pending_count == 0);
      repeat (LAT + 10) @(posedge clock);
      $display("covered %0d splats: field extremes, zero quaternions, random and stalls",
               splats_checked);
      $display("%0d field mismatches", fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("gaussian_splat_attribute_activation_top: match");
      else
         $display("gaussian_splat_attribute_activation_top: mismatch");
      $finish;
   end

endmodule

>>> gaussian_splat_attribute_activation_top.f
hw/rtl/gsaa_pkg.sv
hw/rtl/gsaa_delay.sv
hw/rtl/gsaa_exp.sv
hw/rtl/gsaa_div.sv
hw/rtl/gsaa_sqrt.sv
hw/rtl/gaussian_splat_attribute_activation_top.sv
bench/splat_activation_checker.sv
bench/tb.sv
